[sv/apdt_pkg.sv]
// ----------------------------------------------------------------------------
// apdt_pkg
// shared types and constants of the affine point and direction transform
// ----------------------------------------------------------------------------
package apdt_pkg;

    // matrix coefficients and translations are always 32-bit signed fixed point
    localparam int COEF_BITS = 32;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;

    // configuration register file: 64-bit data, one register every 8 bytes
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 6;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_DIM_MODE    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW0_FIRST  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW0_SECOND = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW1_FIRST  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW1_SECOND = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW2_FIRST  = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW2_SECOND = 3'd6;

    localparam logic [1:0] MODE_PLANAR  = 2'd2;
    localparam logic [1:0] MODE_SPATIAL = 2'd3;

    // identity matrix, zero translation
    localparam logic [63:0] RST_ROW0_FIRST  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW0_SECOND = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_FIRST  = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW1_SECOND = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_FIRST  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_SECOND = 64'h0001_0000_0000_0000;

    localparam logic CMD_POINT     = 1'b0;
    localparam logic CMD_DIRECTION = 1'b1;

    typedef logic [COEF_BITS-1:0] coef_t;
    typedef coef_t [NUM_COLS-1:0] row_t;   // m_r0, m_r1, m_r2, translation
    typedef row_t  [NUM_ROWS-1:0] mat_t;

    // per-request control that travels down the pipeline
    typedef struct packed {
        logic dir;
        logic planar;
        logic last;
    } ctl_t;

endpackage

[sv/apdt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// apdt_cfg_regs
// apb register file holding the dimension mode and the 3x4 matrix
// ----------------------------------------------------------------------------
module apdt_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [apdt_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [apdt_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [apdt_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output apdt_pkg::mat_t                       mat,
    output logic                                 planar
);

    logic [1:0]        mode_reg;
    logic [2:0][63:0]  first_reg;
    logic [2:0][63:0]  second_reg;
    logic              wr_en;
    logic [apdt_pkg::REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[apdt_pkg::APB_ADDR_BITS-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= apdt_pkg::MODE_SPATIAL;
            first_reg[0]  <= apdt_pkg::RST_ROW0_FIRST;
            second_reg[0] <= apdt_pkg::RST_ROW0_SECOND;
            first_reg[1]  <= apdt_pkg::RST_ROW1_FIRST;
            second_reg[1] <= apdt_pkg::RST_ROW1_SECOND;
            first_reg[2]  <= apdt_pkg::RST_ROW2_FIRST;
            second_reg[2] <= apdt_pkg::RST_ROW2_SECOND;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                apdt_pkg::REG_DIM_MODE:    mode_reg      <= pwdata[1:0];
                apdt_pkg::REG_ROW0_FIRST:  first_reg[0]  <= pwdata;
                apdt_pkg::REG_ROW0_SECOND: second_reg[0] <= pwdata;
                apdt_pkg::REG_ROW1_FIRST:  first_reg[1]  <= pwdata;
                apdt_pkg::REG_ROW1_SECOND: second_reg[1] <= pwdata;
                apdt_pkg::REG_ROW2_FIRST:  first_reg[2]  <= pwdata;
                apdt_pkg::REG_ROW2_SECOND: second_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            apdt_pkg::REG_DIM_MODE:    prdata = {62'd0, mode_reg};
            apdt_pkg::REG_ROW0_FIRST:  prdata = first_reg[0];
            apdt_pkg::REG_ROW0_SECOND: prdata = second_reg[0];
            apdt_pkg::REG_ROW1_FIRST:  prdata = first_reg[1];
            apdt_pkg::REG_ROW1_SECOND: prdata = second_reg[1];
            apdt_pkg::REG_ROW2_FIRST:  prdata = first_reg[2];
            apdt_pkg::REG_ROW2_SECOND: prdata = second_reg[2];
            default:                   prdata = '0;
        endcase
    end

    // any mode other than planar runs spatial
    assign planar = (mode_reg == apdt_pkg::MODE_PLANAR);

    always_comb
    begin
        for (int r = 0; r < apdt_pkg::NUM_ROWS; r++)
        begin
            mat[r][0] = first_reg[r][63:32];
            mat[r][1] = first_reg[r][31:0];
            mat[r][2] = second_reg[r][63:32];
            mat[r][3] = second_reg[r][31:0];
        end
    end

endmodule

[sv/apdt_mul_stage.sv]
// ----------------------------------------------------------------------------
// apdt_mul_stage
// first pipeline stage: nine coefficient by coordinate products
// ----------------------------------------------------------------------------
module apdt_mul_stage
#(
    parameter int COORD_BITS = 32,
    parameter int PROD_BITS  = 64
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [2:0][COORD_BITS-1:0]                   coord,
    input  apdt_pkg::ctl_t                               ctl,
    input  apdt_pkg::mat_t                               mat,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [2:0][2:0][PROD_BITS-1:0]               prod,
    output logic [2:0][apdt_pkg::COEF_BITS-1:0]          trans,
    output logic [COORD_BITS-1:0]                        zpass,
    output apdt_pkg::ctl_t                               ctl_out
);

    logic                                       valid_reg;
    logic [2:0][2:0][PROD_BITS-1:0]             prod_reg;
    logic [2:0][2:0][PROD_BITS-1:0]             prod_next;
    logic [2:0][apdt_pkg::COEF_BITS-1:0]        trans_reg;
    logic [2:0][apdt_pkg::COEF_BITS-1:0]        trans_next;
    logic [COORD_BITS-1:0]                      zpass_reg;
    apdt_pkg::ctl_t                             ctl_reg;
    logic                                       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        logic [apdt_pkg::COEF_BITS-1:0] c;
        for (int r = 0; r < apdt_pkg::NUM_ROWS; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c = mat[r][k];
                // planar mode drops the z column of the x and y rows
                if (k == 2 && r < 2 && ctl.planar)
                    c = '0;
                prod_next[r][k] = PROD_BITS'($signed(c)) * PROD_BITS'($signed(coord[k]));
            end
            trans_next[r] = (ctl.dir == apdt_pkg::CMD_DIRECTION) ? '0 : mat[r][3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
            zpass_reg <= coord[2];
            ctl_reg   <= ctl;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;
    assign trans     = trans_reg;
    assign zpass     = zpass_reg;
    assign ctl_out   = ctl_reg;

endmodule

[sv/apdt_sum_stage.sv]
// ----------------------------------------------------------------------------
// apdt_sum_stage
// second pipeline stage: row sums with scaled translation and rounding bias
// ----------------------------------------------------------------------------
module apdt_sum_stage
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int PROD_BITS  = 64,
    parameter int ACC_BITS   = 67
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [2:0][2:0][PROD_BITS-1:0]         prod,
    input  logic [2:0][apdt_pkg::COEF_BITS-1:0]    trans,
    input  logic [COORD_BITS-1:0]                  zpass,
    input  apdt_pkg::ctl_t                         ctl,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0][ACC_BITS-1:0]               acc,
    output logic [COORD_BITS-1:0]                  zpass_out,
    output apdt_pkg::ctl_t                         ctl_out
);

    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic                        valid_reg;
    logic [2:0][ACC_BITS-1:0]    acc_reg;
    logic [2:0][ACC_BITS-1:0]    acc_next;
    logic [COORD_BITS-1:0]       zpass_reg;
    apdt_pkg::ctl_t              ctl_reg;
    logic                        load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int r = 0; r < apdt_pkg::NUM_ROWS; r++)
        begin
            acc_next[r] = ACC_BITS'($signed(prod[r][0]))
                        + ACC_BITS'($signed(prod[r][1]))
                        + ACC_BITS'($signed(prod[r][2]))
                        + (ACC_BITS'($signed(trans[r])) << FRAC_BITS)
                        + HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg   <= acc_next;
            zpass_reg <= zpass;
            ctl_reg   <= ctl;
        end
    end

    assign out_valid = valid_reg;
    assign acc       = acc_reg;
    assign zpass_out = zpass_reg;
    assign ctl_out   = ctl_reg;

endmodule

[sv/apdt_sat_stage.sv]
// ----------------------------------------------------------------------------
// apdt_sat_stage
// last pipeline stage: shift out the fraction, saturate, output register
// ----------------------------------------------------------------------------
module apdt_sat_stage
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ACC_BITS   = 67
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][ACC_BITS-1:0]          acc,
    input  logic [COORD_BITS-1:0]             zpass,
    input  apdt_pkg::ctl_t                    ctl,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0][COORD_BITS-1:0]        res,
    output logic                              ovf,
    output logic                              last
);

    localparam int SH_BITS = ACC_BITS - FRAC_BITS;
    localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                           valid_reg;
    logic [2:0][COORD_BITS-1:0]     res_reg;
    logic [2:0][COORD_BITS-1:0]     res_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           last_reg;
    logic [2:0]                     row_sat;
    logic                           load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        logic [SH_BITS-1:0]           sh;
        logic [SH_BITS-COORD_BITS:0]  top;
        for (int r = 0; r < apdt_pkg::NUM_ROWS; r++)
        begin
            sh  = acc[r][ACC_BITS-1:FRAC_BITS];
            top = sh[SH_BITS-1:COORD_BITS-1];
            if ((&top) || !(|top))
            begin
                res_next[r] = sh[COORD_BITS-1:0];
                row_sat[r]  = 1'b0;
            end
            else
            begin
                res_next[r] = sh[SH_BITS-1] ? SAT_MIN : SAT_MAX;
                row_sat[r]  = 1'b1;
            end
        end
        // planar z is the input z, never saturated
        if (ctl.planar)
        begin
            res_next[2] = zpass;
            row_sat[2]  = 1'b0;
        end
        ovf_next = |row_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            ovf_reg  <= ovf_next;
            last_reg <= ctl.last;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;
    assign ovf       = ovf_reg;
    assign last      = last_reg;

endmodule

[sv/affine_point_direction_transform_unit.sv]
// ----------------------------------------------------------------------------
// affine_point_direction_transform_unit
// fixed-point 3x4 affine transform of points and directions, one per unstalled cycle
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+-----------------------------------------------------------
//  s_t*     | in  | tdata {in_z, in_y, in_x}, tuser cmd, tlast in_last
//  m_t*     | out | tdata {out_z, out_y, out_x}, tuser overflow, tlast out_last
//  apb      | in  | 64-bit registers at 8*index: mode, then three matrix row pairs
//
//  three register stages: multiply, sum and rounding bias, shift and saturate
//  (output register); an accepted request passes the multiply, sum and output
//  registers in that order before it is valid on m_t*
//  one request per cycle sustained without stalls; each stage is a 32 x
//  COORD_BITS multiply or one wide multi-operand add or one compare and select
//  reset clears the stage valid bits and loads identity, spatial mode
//  a stall on m_tready holds each full stage; bubbles still close up
// ----------------------------------------------------------------------------
module affine_point_direction_transform_unit
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [apdt_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [apdt_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [apdt_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,

    // input requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // in_x, in_y, in_z, zero pad
    input  logic [0:0]                            s_tuser,  // cmd
    input  logic                                  s_tlast,

    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,  // out_x, out_y, out_z, zero pad
    output logic [0:0]                            m_tuser,  // overflow
    output logic                                  m_tlast
);

    localparam int DATA_BITS = ((3*COORD_BITS+7)/8)*8;
    // exact product of a 32-bit coefficient and a coordinate
    localparam int PROD_BITS = apdt_pkg::COEF_BITS + COORD_BITS;
    // three products, scaled translation and rounding bias, with headroom
    localparam int ACC_BITS  = ((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS)
                             + apdt_pkg::COEF_BITS + 3;

    apdt_pkg::mat_t                         mat;
    logic                                   planar;

    logic [2:0][COORD_BITS-1:0]             coord;
    apdt_pkg::ctl_t                         in_ctl;

    // multiply stage to sum stage
    logic                                   mul_valid;
    logic                                   sum_ready;
    logic [2:0][2:0][PROD_BITS-1:0]         mul_prod;
    logic [2:0][apdt_pkg::COEF_BITS-1:0]    mul_trans;
    logic [COORD_BITS-1:0]                  mul_zpass;
    apdt_pkg::ctl_t                         mul_ctl;

    // sum stage to saturate stage
    logic                                   sum_valid;
    logic                                   sat_ready;
    logic [2:0][ACC_BITS-1:0]               sum_acc;
    logic [COORD_BITS-1:0]                  sum_zpass;
    apdt_pkg::ctl_t                         sum_ctl;

    // output register
    logic [2:0][COORD_BITS-1:0]             res;
    logic                                   ovf;

    apdt_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat),
        .planar  (planar)
    );

    // unpack the request; mode is sampled with the request
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            coord[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
        in_ctl.dir    = s_tuser[0];
        in_ctl.planar = planar;
        in_ctl.last   = s_tlast;
    end

    apdt_mul_stage #(
        .COORD_BITS (COORD_BITS),
        .PROD_BITS  (PROD_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coord     (coord),
        .ctl       (in_ctl),
        .mat       (mat),
        .out_valid (mul_valid),
        .out_ready (sum_ready),
        .prod      (mul_prod),
        .trans     (mul_trans),
        .zpass     (mul_zpass),
        .ctl_out   (mul_ctl)
    );

    apdt_sum_stage #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .PROD_BITS  (PROD_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (sum_ready),
        .prod      (mul_prod),
        .trans     (mul_trans),
        .zpass     (mul_zpass),
        .ctl       (mul_ctl),
        .out_valid (sum_valid),
        .out_ready (sat_ready),
        .acc       (sum_acc),
        .zpass_out (sum_zpass),
        .ctl_out   (sum_ctl)
    );

    apdt_sat_stage #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sat_ready),
        .acc       (sum_acc),
        .zpass     (sum_zpass),
        .ctl       (sum_ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res),
        .ovf       (ovf),
        .last      (m_tlast)
    );

    // pack results, x in the lowest bits, pad bits zero
    assign m_tdata    = DATA_BITS'({res[2], res[1], res[0]});
    assign m_tuser[0] = ovf;

`ifndef SYNTHESIS
    // input backpressure only when every stage is full and the output stalls
    property p_ready_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (mul_valid && sum_valid && m_tvalid && !m_tready);
    endproperty
    a_ready_only_when_full: assert property (p_ready_only_when_full)
        else $error("input stalled while pipeline has room");

    // an accepted request reaches the output when m_tready does not stall it
    property p_latency;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid;
    endproperty
    a_latency: assert property (p_latency)
        else $error("request lost in pipeline");

    // a planar request carries its input z unchanged into the output register
    property p_sum_to_output;
        @(posedge clk) disable iff (!rst_n)
        (sum_valid && sat_ready && sum_ctl.planar) |=>
            (res[2] == $past(sum_zpass));
    endproperty
    a_sum_to_output: assert property (p_sum_to_output)
        else $error("planar z not passed through");
`endif

endmodule
